>>> src/cpid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpid_pkg
// Shared types, register map and saturation helper for the cascade PID block.
// ----------------------------------------------------------------------------
package cpid_pkg;

  localparam int DATA_W    = 32;
  localparam int DIFF_W    = DATA_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int ACC_W     = DATA_W + 2;
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 8;
  localparam int REG_IDX_W = 3;

  // integral clamp limits in whole units
  localparam longint OUTER_LIM_UNITS = 100;
  localparam longint INNER_LIM_UNITS = 500;

  // register map
  localparam logic [REG_IDX_W-1:0] REG_OUTER_KP      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_OUTER_KI      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_OUTER_KD      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_INNER_KP      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_INNER_KI      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_INNER_KD      = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_DRIVE_FLOOR   = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_DRIVE_CEILING = 3'd7;

  localparam logic signed [DATA_W-1:0] CFG_RESET [NUM_REGS] = '{
    32'sd327680, 32'sd0, 32'sd6554, 32'sd98304,
    32'sd655, 32'sd3277, -32'sd65536000, 32'sd65536000
  };

  typedef struct packed {
    logic signed [DATA_W-1:0] outer_kp;
    logic signed [DATA_W-1:0] outer_ki;
    logic signed [DATA_W-1:0] outer_kd;
    logic signed [DATA_W-1:0] inner_kp;
    logic signed [DATA_W-1:0] inner_ki;
    logic signed [DATA_W-1:0] inner_kd;
    logic signed [DATA_W-1:0] drive_floor;
    logic signed [DATA_W-1:0] drive_ceiling;
  } cpid_gains_t;

  typedef struct packed {
    logic                     start;
    logic signed [DATA_W-1:0] dividend;
  } cpid_div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] quotient;
  } cpid_div_rsp_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 66'sh0_7fff_ffff) begin
      r = 32'sh7fff_ffff;
    end else if (v < -66'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> src/cascade_pid_position_velocity.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascade_pid_position_velocity
// Position PID feeding a velocity PID, signed fixed point, one drive per tick.
// ----------------------------------------------------------------------------
//  channel   dir  word                                   handshake
//  s_axis    in   target, measured pos, measured vel     tvalid / tready
//  m_axis    out  drive_value                            tvalid / tready
//  cfg       in   register index, register data          valid / ready
//
//  An item passes through the idle step to accept, two loop passes (error
//  step, a wait on the reciprocal divider, seven steps on the shared
//  multiplier and adder), then a result step that hands the word to the
//  output register, which raises tvalid.
//  s_axis_tready_o is high only while no item is in flight; a waiting
//  result word holds the block in its last step until it is taken.
//  Reset loads the default gains and clears both loop states; any write to a
//  mapped register clears them again. cfg_ready_o is always high.
// ----------------------------------------------------------------------------
module cascade_pid_position_velocity #(
  parameter int DT_RECIP  = 100,
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [31:0] target_position, [63:32] measured_position, [95:64] measured_velocity
  input  logic [3*cpid_pkg::DATA_W-1:0]   s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [31:0] drive_value
  output logic [cpid_pkg::DATA_W-1:0]     m_axis_tdata_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cpid_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cpid_pkg::DATA_W-1:0]     cfg_data_i
);
  import cpid_pkg::*;

  cpid_gains_t              gains;
  logic                     clr;
  cpid_div_req_t            div_req;
  cpid_div_rsp_t            div_rsp;
  logic signed [DATA_W-1:0] drive_value;

  cpid_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .gains_o     (gains),
    .clr_o       (clr)
  );

  cpid_div #(
    .DIVISOR (DT_RECIP)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  cpid_seq #(
    .DT_RECIP  (DT_RECIP),
    .FRAC_BITS (FRAC_BITS)
  ) u_seq (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .gains_i             (gains),
    .clr_i               (clr),
    .in_valid_i          (s_axis_tvalid_i),
    .in_ready_o          (s_axis_tready_o),
    .target_position_i   (s_axis_tdata_i[DATA_W-1:0]),
    .measured_position_i (s_axis_tdata_i[2*DATA_W-1:DATA_W]),
    .measured_velocity_i (s_axis_tdata_i[3*DATA_W-1:2*DATA_W]),
    .out_valid_o         (m_axis_tvalid_o),
    .out_ready_i         (m_axis_tready_i),
    .drive_value_o       (drive_value),
    .div_req_o           (div_req),
    .div_rsp_i           (div_rsp)
  );

  assign m_axis_tdata_o = drive_value;

endmodule

>>> src/cpid_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpid_regs
// Gain and drive limit registers, with a state clear pulse on mapped writes.
// ----------------------------------------------------------------------------
module cpid_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cpid_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [cpid_pkg::DATA_W-1:0]    cfg_data_i,
  output cpid_pkg::cpid_gains_t          gains_o,
  output logic                           clr_o
);
  import cpid_pkg::*;

  logic signed [DATA_W-1:0] regs_q [NUM_REGS];
  logic                     wr_en;

  assign cfg_ready_o = 1'b1;
  // drop writes beyond the register map
  assign wr_en = cfg_valid_i && (cfg_index_i < CFG_IDX_W'(NUM_REGS));
  assign clr_o = wr_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_q[i] <= CFG_RESET[i];
      end
    end else if (wr_en) begin
      regs_q[cfg_index_i[REG_IDX_W-1:0]] <= cfg_data_i;
    end
  end

  assign gains_o.outer_kp      = regs_q[REG_OUTER_KP];
  assign gains_o.outer_ki      = regs_q[REG_OUTER_KI];
  assign gains_o.outer_kd      = regs_q[REG_OUTER_KD];
  assign gains_o.inner_kp      = regs_q[REG_INNER_KP];
  assign gains_o.inner_ki      = regs_q[REG_INNER_KI];
  assign gains_o.inner_kd      = regs_q[REG_INNER_KD];
  assign gains_o.drive_floor   = regs_q[REG_DRIVE_FLOOR];
  assign gains_o.drive_ceiling = regs_q[REG_DRIVE_CEILING];

endmodule

>>> src/cpid_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpid_div
// Divider by a build-time constant through a reciprocal multiply, truncating
// toward zero. Done follows start through the busy and done registers.
// ----------------------------------------------------------------------------
module cpid_div #(
  parameter int DIVISOR = 100
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cpid_pkg::cpid_div_req_t   req_i,
  output cpid_pkg::cpid_div_rsp_t   rsp_o
);
  import cpid_pkg::*;

  // a magnitude of at most 2^31 times ceil(2^SHIFT / DIVISOR), shifted down by
  // SHIFT, is the exact floor as long as 2^SHIFT >= 2^31 * DIVISOR
  localparam int     LOG_D     = $clog2(DIVISOR);
  localparam int     SHIFT     = DATA_W - 1 + LOG_D;
  localparam longint RECIP_RAW = ((longint'(1) << SHIFT) + longint'(DIVISOR) - 1)
                                 / longint'(DIVISOR);
  localparam logic [DATA_W-1:0] RECIP = DATA_W'(RECIP_RAW);

  logic                busy_q;
  logic                done_q;
  logic                neg_q;
  logic [DATA_W-1:0]   mag_q;
  logic [2*DATA_W-1:0] prod_q;
  logic [DATA_W-1:0]   mag;
  logic [DATA_W-1:0]   quo_mag;

  assign mag     = req_i.dividend[DATA_W-1] ? (~req_i.dividend + 1'b1) : req_i.dividend;
  assign quo_mag = DATA_W'(prod_q >> SHIFT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= req_i.start;
      done_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mag_q <= mag;
      neg_q <= req_i.dividend[DATA_W-1];
    end
    if (busy_q) begin
      prod_q <= (2*DATA_W)'(mag_q) * (2*DATA_W)'(RECIP);
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? -$signed(quo_mag) : $signed(quo_mag);

endmodule

>>> src/cpid_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpid_seq
// Step sequencer around one shared 33x33 multiplier, running both PID loops.
// ----------------------------------------------------------------------------
module cpid_seq #(
  parameter int DT_RECIP  = 100,
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  cpid_pkg::cpid_gains_t          gains_i,
  input  logic                           clr_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [cpid_pkg::DATA_W-1:0] target_position_i,
  input  logic signed [cpid_pkg::DATA_W-1:0] measured_position_i,
  input  logic signed [cpid_pkg::DATA_W-1:0] measured_velocity_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [cpid_pkg::DATA_W-1:0] drive_value_o,
  output cpid_pkg::cpid_div_req_t        div_req_o,
  input  cpid_pkg::cpid_div_rsp_t        div_rsp_i
);
  import cpid_pkg::*;

  localparam longint LIM_OUTER_RAW = OUTER_LIM_UNITS << FRAC_BITS;
  localparam longint LIM_INNER_RAW = INNER_LIM_UNITS << FRAC_BITS;
  localparam logic signed [DATA_W-1:0] LIM_OUTER =
    (LIM_OUTER_RAW > 64'sd2147483647) ? 32'sh7fff_ffff : DATA_W'(LIM_OUTER_RAW);
  localparam logic signed [DATA_W-1:0] LIM_INNER =
    (LIM_INNER_RAW > 64'sd2147483647) ? 32'sh7fff_ffff : DATA_W'(LIM_INNER_RAW);
  localparam logic signed [DIFF_W-1:0] DT_OP = DIFF_W'(DT_RECIP);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ERR  = 4'd1;
  localparam logic [3:0] S_DIVW = 4'd2;
  localparam logic [3:0] S_MDT  = 4'd3;
  localparam logic [3:0] S_DER  = 4'd4;
  localparam logic [3:0] S_MP   = 4'd5;
  localparam logic [3:0] S_MI   = 4'd6;
  localparam logic [3:0] S_MD   = 4'd7;
  localparam logic [3:0] S_ADD  = 4'd8;
  localparam logic [3:0] S_SUM  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0]               state_q, state_d;
  logic                     loop_q;
  logic signed [DATA_W-1:0] sp_q, meas_q, vel_q;
  logic signed [DATA_W-1:0] err_q, deriv_q, res_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [DATA_W-1:0] integ_q [2];
  logic signed [DATA_W-1:0] last_q [2];
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] out_data_q;

  logic signed [DATA_W-1:0] err_d, term, sum_sat, lim, integ_new, drive;
  logic signed [DATA_W-1:0] kp, ki, kd;
  logic signed [DIFF_W-1:0] mul_a, mul_b, integ_sum;
  logic                     load_out;

  assign kp  = loop_q ? gains_i.inner_kp : gains_i.outer_kp;
  assign ki  = loop_q ? gains_i.inner_ki : gains_i.outer_ki;
  assign kd  = loop_q ? gains_i.inner_kd : gains_i.outer_kd;
  assign lim = loop_q ? LIM_INNER : LIM_OUTER;

  assign err_d = sat32(PROD_W'(DIFF_W'(sp_q) - DIFF_W'(meas_q)));
  assign term  = sat32(prod_q >>> FRAC_BITS);
  assign sum_sat = sat32(PROD_W'(acc_q));

  assign integ_sum = DIFF_W'(integ_q[loop_q]) + DIFF_W'(div_rsp_i.quotient);
  always_comb begin
    if (integ_sum > DIFF_W'(lim)) begin
      integ_new = lim;
    end else if (integ_sum < -DIFF_W'(lim)) begin
      integ_new = -lim;
    end else begin
      integ_new = integ_sum[DATA_W-1:0];
    end
  end

  // ceiling first, floor wins when the two cross
  always_comb begin
    drive = sum_sat;
    if (drive > gains_i.drive_ceiling) drive = gains_i.drive_ceiling;
    if (drive < gains_i.drive_floor) drive = gains_i.drive_floor;
  end

  always_comb begin
    unique case (state_q)
      S_MDT: begin
        mul_a = diff_q;
        mul_b = DT_OP;
      end
      S_MP: begin
        mul_a = DIFF_W'(kp);
        mul_b = DIFF_W'(err_q);
      end
      S_MI: begin
        mul_a = DIFF_W'(ki);
        mul_b = DIFF_W'(integ_q[loop_q]);
      end
      S_MD: begin
        mul_a = DIFF_W'(kd);
        mul_b = DIFF_W'(deriv_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod_d = mul_a * mul_b;

  assign div_req_o.start    = (state_q == S_ERR);
  assign div_req_o.dividend = err_d;

  assign in_ready_o = (state_q == S_IDLE);
  assign load_out   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_ERR;
      S_ERR:   state_d = S_DIVW;
      S_DIVW:  if (div_rsp_i.done) state_d = S_MDT;
      S_MDT:   state_d = S_DER;
      S_DER:   state_d = S_MP;
      S_MP:    state_d = S_MI;
      S_MI:    state_d = S_MD;
      S_MD:    state_d = S_ADD;
      S_ADD:   state_d = S_SUM;
      S_SUM:   state_d = loop_q ? S_OUT : S_ERR;
      S_OUT:   if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      loop_q      <= 1'b0;
      out_valid_q <= 1'b0;
      integ_q[0]  <= '0;
      integ_q[1]  <= '0;
      last_q[0]   <= '0;
      last_q[1]   <= '0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (clr_i) begin
        integ_q[0] <= '0;
        integ_q[1] <= '0;
        last_q[0]  <= '0;
        last_q[1]  <= '0;
      end else begin
        if (state_q == S_ERR) last_q[loop_q] <= meas_q;
        if (state_q == S_DIVW && div_rsp_i.done) integ_q[loop_q] <= integ_new;
      end
      if (state_q == S_IDLE && in_valid_i) begin
        loop_q <= 1'b0;
      end else if (state_q == S_SUM && !loop_q) begin
        loop_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    unique case (state_q)
      S_IDLE: begin
        sp_q   <= target_position_i;
        meas_q <= measured_position_i;
        vel_q  <= measured_velocity_i;
      end
      S_ERR: begin
        err_q  <= err_d;
        diff_q <= DIFF_W'(meas_q) - DIFF_W'(last_q[loop_q]);
      end
      S_DER:   deriv_q <= sat32(-prod_q);
      S_MI:    acc_q   <= ACC_W'(term);
      S_MD:    acc_q   <= acc_q + ACC_W'(term);
      S_ADD:   acc_q   <= acc_q + ACC_W'(term);
      S_SUM: begin
        // outer result becomes the velocity setpoint
        sp_q   <= sum_sat;
        meas_q <= vel_q;
        res_q  <= drive;
      end
      S_OUT:   if (load_out) out_data_q <= res_q;
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign drive_value_o = out_data_q;

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp_i.done |-> state_q == S_DIVW)
    else $error("divider finished outside its wait step");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_ERR)
    else $error("accepted word did not start the outer loop");

  a_outer_integ_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    integ_q[0] <= LIM_OUTER && integ_q[0] >= -LIM_OUTER)
    else $error("outer integral outside its clamp");

  a_out_after_inner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT |-> loop_q)
    else $error("result step reached before the inner loop");

  a_valid_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT)
    else $error("result word raised outside the result step");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the cascade position/velocity PID. A behavioral
// copy of both loops predicts each drive word from the accepted tick and the
// current gain set. A checker compares every returned word against the oldest
// prediction. Directed ticks at default and saturating gains, crossed drive
// limits and unmapped indexes come first. Then randomized ticks run under
// three back-pressure profiles and a series of random gain sets.
// ----------------------------------------------------------------------------
module testbench;
  import cpid_pkg::*;

  localparam int     DT_RECIP         = 100;
  localparam int     FRAC_BITS        = 16;
  localparam int     CLK_HALF         = 10;
  localparam int     RESET_CYCLES     = 8;
  localparam int     TAIL_CYCLES      = 200;
  localparam longint CYCLE_LIMIT      = 1_500_000;
  localparam int     BLOCKS_PER_PHASE = 4;
  localparam int     ITEMS_PER_BLOCK  = 150;
  localparam int     MAX_PRINTED      = 25;

  localparam longint S32_MAX = 64'sh0000_0000_7fff_ffff;
  localparam longint S32_MIN = -64'sh0000_0000_8000_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNMAPPED_LO = CFG_IDX_W'(NUM_REGS);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNMAPPED_HI = '1;

  localparam logic [DATA_W-1:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] ONE_Q    = 32'h0001_0000;
  localparam logic [DATA_W-1:0] HALF_K_Q = 32'h01f4_0000;  // 500.0

  typedef struct packed {
    logic signed [DATA_W-1:0] vel;
    logic signed [DATA_W-1:0] pos;
    logic signed [DATA_W-1:0] target;
  } tick_t;

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  // [31:0] target_position, [63:32] measured_position, [95:64] measured_velocity
  logic [3*DATA_W-1:0]    s_axis_tdata_i  = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  // [31:0] drive_value
  logic [DATA_W-1:0]      m_axis_tdata_o;
  logic                   cfg_valid_i     = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i     = '0;
  logic [DATA_W-1:0]      cfg_data_i      = '0;

  // predictor copy of the gains and both loop states
  longint            gain_q [NUM_REGS];
  longint            pos_integral, pos_last, vel_integral, vel_last;
  logic [DATA_W-1:0] pending_regs [NUM_REGS];
  logic [DATA_W-1:0] drive_expected_q [$];

  int     mismatches     = 0;
  int     ticks_sent     = 0;
  int     drives_checked = 0;
  int     reg_writes     = 0;
  int     gain_sets      = 0;
  int     src_gap_pct    = 0;
  int     sink_gap_pct   = 0;
  longint cycle_count    = 0;
  longint track_target   = 0;
  longint track_pos      = 0;
  longint track_vel      = 0;

  cascade_pid_position_velocity #(
    .DT_RECIP (DT_RECIP),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout at cycle %0d with %0d drive words outstanding",
               cycle_count, drive_expected_q.size());
      $display("[cascade_pid_position_velocity] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) m_axis_tready_i <= ($urandom_range(99) >= sink_gap_pct);

  // ---------------------------------------------------------------- predictor

  function automatic longint clip32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // arithmetic shift on a signed product rounds toward minus infinity
  function automatic longint fixed_mul(input longint g, input longint x);
    return clip32((g * x) >>> FRAC_BITS);
  endfunction

  task automatic pid_pass(input longint setpoint, input longint meas,
                          input longint kp, input longint ki, input longint kd,
                          input longint lim_units, inout longint integ,
                          inout longint last, output longint u);
    longint lim, err, deriv;
    lim   = clip32(lim_units <<< FRAC_BITS);
    err   = clip32(setpoint - meas);
    integ = integ + err / DT_RECIP;
    if (integ > lim) integ = lim;
    if (integ < -lim) integ = -lim;
    deriv = clip32(-((meas - last) * DT_RECIP));
    last  = meas;
    u     = clip32(fixed_mul(kp, err) + fixed_mul(ki, integ) + fixed_mul(kd, deriv));
  endtask

  task automatic predict_drive(input tick_t t);
    longint vset, drive;
    pid_pass(longint'(t.target), longint'(t.pos), gain_q[REG_OUTER_KP],
             gain_q[REG_OUTER_KI], gain_q[REG_OUTER_KD], OUTER_LIM_UNITS,
             pos_integral, pos_last, vset);
    pid_pass(vset, longint'(t.vel), gain_q[REG_INNER_KP], gain_q[REG_INNER_KI],
             gain_q[REG_INNER_KD], INNER_LIM_UNITS, vel_integral, vel_last, drive);
    // floor wins when the limits cross
    if (drive > gain_q[REG_DRIVE_CEILING]) drive = gain_q[REG_DRIVE_CEILING];
    if (drive < gain_q[REG_DRIVE_FLOOR]) drive = gain_q[REG_DRIVE_FLOOR];
    drive_expected_q.push_back(drive[DATA_W-1:0]);
  endtask

  function automatic void clear_loops();
    pos_integral = 0;
    pos_last     = 0;
    vel_integral = 0;
    vel_last     = 0;
  endfunction

  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [DATA_W-1:0] val);
    if (idx < NUM_REGS) begin
      gain_q[idx[REG_IDX_W-1:0]] = longint'($signed(val));
      clear_loops();
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTED) $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : drive_check
    logic [DATA_W-1:0] want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (drive_expected_q.size() == 0) begin
        report_mismatch($sformatf("drive word %h with no tick outstanding", m_axis_tdata_o));
      end else begin
        want = drive_expected_q.pop_front();
        drives_checked++;
        if (m_axis_tdata_o !== want) begin
          report_mismatch($sformatf("drive_value %h, expected %h (word %0d)",
                                    m_axis_tdata_o, want, drives_checked));
        end
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  function automatic tick_t make_tick(input logic [DATA_W-1:0] target,
                                      input logic [DATA_W-1:0] pos,
                                      input logic [DATA_W-1:0] vel);
    tick_t t;
    t.target = target;
    t.pos    = pos;
    t.vel    = vel;
    return t;
  endfunction

  // valid stays high between back-to-back ticks; drop it only on a gap
  task automatic send_tick(input tick_t t);
    while ($urandom_range(99) < src_gap_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {t.vel, t.pos, t.target};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_drive(t);
    ticks_sent++;
  endtask

  // hold the sender until every drive word is back and the block is free
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (drive_expected_q.size() != 0 || !s_axis_tready_o);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg_write(idx, val);
    reg_writes++;
  endtask

  task automatic load_settings();
    wait_idle();
    for (int i = 0; i < NUM_REGS; i++) write_reg(CFG_IDX_W'(i), pending_regs[i]);
    cfg_valid_i <= 1'b0;
    gain_sets++;
  endtask

  function automatic void stage_defaults();
    for (int i = 0; i < NUM_REGS; i++) pending_regs[i] = CFG_RESET[i];
  endfunction

  // ---------------------------------------------------------------- random values

  function automatic logic [DATA_W-1:0] corner_word();
    case ($urandom_range(5))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return '0;
      3:       return '1;
      4:       return ONE_Q;
      default: return -ONE_Q;
    endcase
  endfunction

  // uniform in +-span_units whole units
  function automatic logic [DATA_W-1:0] modest_word(input int unsigned span_units);
    int unsigned span;
    span = span_units << FRAC_BITS;
    return DATA_W'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic [DATA_W-1:0] random_gain();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 6) return modest_word(8);
    if (pick < 8) return $urandom;
    return corner_word();
  endfunction

  task automatic stage_random_settings();
    int unsigned pick;
    pending_regs[REG_OUTER_KP] = random_gain();
    pending_regs[REG_OUTER_KI] = random_gain();
    pending_regs[REG_OUTER_KD] = random_gain();
    pending_regs[REG_INNER_KP] = random_gain();
    pending_regs[REG_INNER_KI] = random_gain();
    pending_regs[REG_INNER_KD] = random_gain();
    pick = $urandom_range(9);
    if (pick < 7) begin
      pending_regs[REG_DRIVE_FLOOR]   = -DATA_W'($urandom_range(1, 1500) << FRAC_BITS);
      pending_regs[REG_DRIVE_CEILING] = DATA_W'($urandom_range(1, 1500) << FRAC_BITS);
    end else if (pick < 9) begin
      pending_regs[REG_DRIVE_FLOOR]   = $urandom;
      pending_regs[REG_DRIVE_CEILING] = $urandom;
    end else begin
      // crossed limits
      pending_regs[REG_DRIVE_FLOOR]   = DATA_W'($urandom_range(1, 500) << FRAC_BITS);
      pending_regs[REG_DRIVE_CEILING] = -DATA_W'($urandom_range(1, 500) << FRAC_BITS);
    end
  endtask

  // mostly a plant that follows a wandering target, the rest loose values
  task automatic make_random_tick(output tick_t t);
    int unsigned pick;
    longint      delta;
    pick = $urandom_range(19);
    if (pick < 12) begin
      if ($urandom_range(39) == 0) track_target = longint'($signed(modest_word(300)));
      delta     = (track_target - track_pos) / 8 + longint'($signed(modest_word(1)));
      track_pos = clip32(track_pos + delta);
      track_vel = clip32(delta * DT_RECIP + longint'($signed(modest_word(2))));
      t = make_tick(track_target[DATA_W-1:0], track_pos[DATA_W-1:0],
                    track_vel[DATA_W-1:0]);
    end else if (pick < 17) begin
      t = make_tick(modest_word(400), modest_word(400), modest_word(400));
    end else if (pick < 19) begin
      t = make_tick($urandom, $urandom, $urandom);
    end else begin
      t = make_tick(corner_word(), corner_word(), corner_word());
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_default_gains();
    send_tick(make_tick('0, '0, '0));
    send_tick(make_tick(ONE_Q, '0, '0));
    send_tick(make_tick(ONE_Q, '0, '0));
    send_tick(make_tick(WORD_MAX, WORD_MIN, '0));
    send_tick(make_tick(WORD_MIN, WORD_MAX, WORD_MAX));
    send_tick(make_tick('0, '0, WORD_MIN));
    send_tick(make_tick('1, ONE_Q, '0));
    send_tick(make_tick('0, '0, '0));
  endtask

  task automatic test_saturating_gains();
    pending_regs[REG_OUTER_KP]      = WORD_MAX;
    pending_regs[REG_OUTER_KI]      = WORD_MIN;
    pending_regs[REG_OUTER_KD]      = WORD_MAX;
    pending_regs[REG_INNER_KP]      = WORD_MIN;
    pending_regs[REG_INNER_KI]      = WORD_MAX;
    pending_regs[REG_INNER_KD]      = WORD_MIN;
    pending_regs[REG_DRIVE_FLOOR]   = WORD_MIN;
    pending_regs[REG_DRIVE_CEILING] = WORD_MAX;
    load_settings();
    send_tick(make_tick(WORD_MAX, WORD_MIN, WORD_MIN));
    send_tick(make_tick(WORD_MIN, WORD_MAX, WORD_MAX));
    send_tick(make_tick(ONE_Q, '1, ONE_Q));
    send_tick(make_tick('0, '0, '0));
  endtask

  task automatic test_crossed_limits();
    stage_defaults();
    pending_regs[REG_DRIVE_FLOOR]   = HALF_K_Q;
    pending_regs[REG_DRIVE_CEILING] = -HALF_K_Q;
    load_settings();
    send_tick(make_tick(modest_word(50), modest_word(50), modest_word(50)));
    send_tick(make_tick(WORD_MIN, WORD_MAX, '0));
  endtask

  // writes to unmapped indexes must leave gains and loop state alone
  task automatic test_unmapped_index();
    stage_defaults();
    load_settings();
    send_tick(make_tick(modest_word(20), modest_word(20), modest_word(20)));
    send_tick(make_tick(modest_word(20), modest_word(20), modest_word(20)));
    wait_idle();
    write_reg(CFG_IDX_UNMAPPED_LO, $urandom);
    write_reg(CFG_IDX_UNMAPPED_HI, $urandom);
    cfg_valid_i <= 1'b0;
    send_tick(make_tick(modest_word(20), modest_word(20), modest_word(20)));
    send_tick(make_tick(modest_word(20), modest_word(20), modest_word(20)));
  endtask

  task automatic test_random_phase(input int src_pct, input int sink_pct);
    tick_t t;
    src_gap_pct  = src_pct;
    sink_gap_pct = sink_pct;
    for (int b = 0; b < BLOCKS_PER_PHASE; b++) begin
      if (b == 0) stage_defaults();
      else stage_random_settings();
      load_settings();
      for (int n = 0; n < ITEMS_PER_BLOCK; n++) begin
        if (n == ITEMS_PER_BLOCK / 2) wait_idle();
        make_random_tick(t);
        send_tick(t);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_REGS; i++) gain_q[i] = CFG_RESET[i];
    clear_loops();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_default_gains();
    test_saturating_gains();
    test_crossed_limits();
    test_unmapped_index();
    test_random_phase(12, 63);
    test_random_phase(63, 12);
    test_random_phase(0, 0);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (drive_expected_q.size() != 0) begin
      report_mismatch($sformatf("%0d drive words never arrived", drive_expected_q.size()));
    end
    $display("covered %0d ticks and %0d drive words over %0d gain sets (%0d register writes)",
             ticks_sent, drives_checked, gain_sets, reg_writes);
    $display("incl. saturating gains, crossed drive limits, unmapped indexes; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("[cascade_pid_position_velocity] OK");
    end else begin
      $display("[cascade_pid_position_velocity] ERROR");
    end
    $finish;
  end

endmodule
